// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

`endif

// ===== rtl/lifs_pkg.sv =====
// Package with the constants, tables, types and helper function of the icon fade sequencer.
`default_nettype none

package lifs_pkg;

   localparam int ICON_COUNT      = 6;
   localparam int GRID_WIDTH      = 8;
   localparam int GRID_HEIGHT     = 8;
   localparam int PALETTE_ENTRIES = 14;

   localparam int DELTA_W    = 20;
   localparam int TIME_W     = 24;
   localparam int PHASE_W    = 25;
   localparam int SUM_W      = 26;
   localparam int ICON_W     = 3;
   localparam int COORD_W    = 3;
   localparam int CELL_W     = 4;
   localparam int WEIGHT_W   = 8;
   localparam int LEVEL_W    = 8;
   localparam int GAIN_W     = 8;
   localparam int FRAC_BITS  = 16;
   localparam int FADE_W     = FRAC_BITS + 1;
   localparam int BD_W       = 2 * GAIN_W;
   localparam int SCALE_W    = BD_W + FADE_W;
   localparam int PROD_W     = SCALE_W + WEIGHT_W;
   localparam int LEVEL_SHIFT = FRAC_BITS + 2 * GAIN_W;
   localparam int DIV_STEP_W = 5;
   localparam int WRAP_STEPS = SUM_W;
   localparam int FADE_STEPS = FADE_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = TIME_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * COORD_W - 3 * LEVEL_W;

   localparam logic [FADE_W-1:0] FADE_FULL = FADE_W'(1) << FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS_CAP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_IN_TIME   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TIME      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_OUT_TIME  = 3'd4;

   localparam logic [GAIN_W-1:0] BRIGHTNESS_RESET = 8'd255;
   localparam logic [GAIN_W-1:0] DAMPING_RESET    = 8'd102;
   localparam logic [TIME_W-1:0] FADE_IN_RESET    = 24'd500000;
   localparam logic [TIME_W-1:0] HOLD_RESET       = 24'd3000000;
   localparam logic [TIME_W-1:0] FADE_OUT_RESET   = 24'd500000;

   // Palette entries as {red, green, blue}, each in Q0.8.
   localparam logic [3*WEIGHT_W-1:0] PALETTE [16] = '{
      24'h0DE60D, 24'h0DCD0D, 24'h402E0D, 24'h332608,
      24'h000000, 24'hFFA600, 24'hFF0000, 24'hFFFFF3,
      24'h000000, 24'h0DDA0D, 24'h8000CD, 24'h9A00FF,
      24'h00E6E6, 24'hE6DAB3, 24'h000000, 24'h000000
   };

   // Authored icon rows; column c sits in nibble 7-c of each word.
   localparam logic [31:0] ICON_ROWS [8][8] = '{
      '{32'h99999999, 32'h98899889, 32'h98899889, 32'h99988999,
        32'h99888899, 32'h99888899, 32'h99899899, 32'h99999999},
      '{32'h00000000, 32'h10110012, 32'h12212202, 32'h23223222,
        32'h22223222, 32'h23222232, 32'h22232222, 32'h22222222},
      '{32'h44444444, 32'h45544454, 32'h44544554, 32'h44444544,
        32'h44544444, 32'h44554444, 32'h44444544, 32'h45444444},
      '{32'h66666666, 32'h66666666, 32'h77777777, 32'h88888888,
        32'h78788787, 32'h77777777, 32'h66666666, 32'h66666666},
      '{32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888,
        32'hABA88ABA, 32'h88888888, 32'h88888888, 32'h88888888},
      '{32'h44444444, 32'h4CC444C4, 32'h44C44CC4, 32'h44444C44,
        32'h44C44444, 32'h44CC4444, 32'h44444C44, 32'h4C444444},
      '{32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888,
        32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888},
      '{32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888,
        32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888}
   };

   typedef enum logic [1:0] {
      FADE_UP,
      FADE_HOLD,
      FADE_OFF,
      FADE_DOWN
   } fade_kind_type;

   typedef struct packed {
      logic load_wrap;
      logic clear_phase;
      logic commit_wrap;
      logic start_fade;
      logic const_fade;
      logic commit_fade;
      logic scale_a;
      logic scale_b;
      logic pix_issue;
   } cmd_type;

   typedef struct packed {
      logic          cycle_zero;
      logic          div_busy;
      fade_kind_type fade_kind;
      logic          pipe_advance;
      logic          pix_last;
      logic          s1_valid;
   } sts_type;

   function automatic logic [3*WEIGHT_W-1:0] pixel_weight(
      input logic [ICON_W-1:0]  icon,
      input logic [COORD_W-1:0] row,
      input logic [COORD_W-1:0] col
   );
      logic [31:0]       word;
      logic [CELL_W-1:0] entry;
      word  = ICON_ROWS[icon][row];
      entry = CELL_W'(word >> (CELL_W * (3'd7 - col)));
      if (32'(entry) < PALETTE_ENTRIES) begin
         return PALETTE[entry];
      end
      return '0;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/led_icon_fade_sequencer.sv =====
// Top level of the LED icon fade sequencer: controller, datapath and port packing.
//
// One req transaction carries the microseconds since the previous frame. The block
// advances its phase timer, steps the icon when whole cycles (hold plus fade-out) have
// passed, forms the fade level and then sends the 64 pixels of the current icon,
// rotated 180 degrees, as 64 rsp transactions, row by row; rsp_tlast marks the last.
// The csr channel writes the five registers (index 0 to 4); it is always ready and
// writes are meant to be made only while no frame is in progress.
// On a fade ramp a frame runs, from acceptance until req_tready rises again, through
// the 26-step divider pass of the timer wrap, the 17-step pass of the same divider
// for the fade ramp, the two scaling states, the issue of the 64 pixels and the drain
// of the pixel pipeline. At full or zero fade the fade pass is skipped, and with a
// zero cycle length the wrap pass is skipped as well.
// req_tready is high only between frames. When the receiver stalls, the pixel
// pipeline and the output register hold and the frame simply takes longer.
// Reset is synchronous: registers return to their default values, the phase timer
// and icon index clear, and any frame in progress is dropped.
`default_nettype none

module led_icon_fade_sequencer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [19:0] delta_us, [23:20] zero
   input  wire logic [lifs_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [2:0] pixel_x, [5:3] pixel_y, [13:6] red_level, [21:14] green_level,
   // [29:22] blue_level, [31:30] zero
   output logic [lifs_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lifs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [lifs_pkg::CSR_DATA_W-1:0]      csr_data
);

   lifs_pkg::cmd_type cmd;
   lifs_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   lifs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lifs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .delta_us   (req_tdata[lifs_pkg::DELTA_W-1:0]),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/lifs_div.sv =====
// Bit-serial restoring divider that also tracks the quotient modulo the icon count.
`default_nettype none

module lifs_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [lifs_pkg::PHASE_W-1:0]    rem_init,
   input  wire logic [lifs_pkg::SUM_W-1:0]      bits_init,
   input  wire logic [lifs_pkg::PHASE_W-1:0]    divisor,
   input  wire logic [lifs_pkg::DIV_STEP_W-1:0] steps,
   output logic                                 busy,
   output logic [lifs_pkg::PHASE_W-1:0]         rem,
   output logic [lifs_pkg::FADE_W-1:0]          quot,
   output logic [lifs_pkg::ICON_W-1:0]          qmod
);

   logic                              busy_ff, busy_in;
   logic [lifs_pkg::PHASE_W-1:0]      rem_ff, rem_in;
   logic [lifs_pkg::SUM_W-1:0]        bits_ff, bits_in;
   logic [lifs_pkg::PHASE_W-1:0]      dvs_ff, dvs_in;
   logic [lifs_pkg::DIV_STEP_W-1:0]   cnt_ff, cnt_in;
   logic [lifs_pkg::FADE_W-1:0]       quot_ff, quot_in;
   logic [lifs_pkg::ICON_W-1:0]       qmod_ff, qmod_in;
   logic [lifs_pkg::PHASE_W:0]        trial;
   logic [lifs_pkg::PHASE_W:0]        dvs_ext;
   logic                              ge;
   logic [lifs_pkg::ICON_W:0]         mod_sum;

   always_comb begin
      dvs_ext = {1'b0, dvs_ff};
      trial   = {rem_ff, bits_ff[lifs_pkg::SUM_W-1]};
      ge      = trial >= dvs_ext;
      mod_sum = {qmod_ff, ge};
      if (32'(mod_sum) >= lifs_pkg::ICON_COUNT) begin
         mod_sum = mod_sum - (lifs_pkg::ICON_W + 1)'(lifs_pkg::ICON_COUNT);
      end

      busy_in = busy_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      qmod_in = qmod_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = rem_init;
         bits_in = bits_init;
         dvs_in  = divisor;
         cnt_in  = steps;
         quot_in = '0;
         qmod_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? lifs_pkg::PHASE_W'(trial - dvs_ext) : lifs_pkg::PHASE_W'(trial);
         bits_in = bits_ff << 1;
         quot_in = {quot_ff[lifs_pkg::FADE_W-2:0], ge};
         qmod_in = lifs_pkg::ICON_W'(mod_sum);
         cnt_in  = cnt_ff - lifs_pkg::DIV_STEP_W'(1);
         busy_in = cnt_ff != lifs_pkg::DIV_STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      qmod_ff <= qmod_in;
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;
   assign quot = quot_ff;
   assign qmod = qmod_ff;

endmodule

`default_nettype wire

// ===== rtl/lifs_datapath.sv =====
// Datapath: registers, phase timer, icon index, fade, scale and the pixel pipeline.
`default_nettype none

module lifs_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lifs_pkg::cmd_type                 cmd,
   output lifs_pkg::sts_type                      sts,
   input  wire logic [lifs_pkg::DELTA_W-1:0]      delta_us,
   input  wire logic                              csr_write,
   input  wire logic [lifs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lifs_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lifs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast
);

   logic [lifs_pkg::GAIN_W-1:0]   bright_ff, damp_ff;
   logic [lifs_pkg::TIME_W-1:0]   fade_in_ff, hold_ff, fade_out_ff;
   logic [lifs_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [lifs_pkg::ICON_W-1:0]   icon_ff, icon_in;
   logic [lifs_pkg::FADE_W-1:0]   fade_ff;
   logic [lifs_pkg::BD_W-1:0]     bd_ff;
   logic [lifs_pkg::SCALE_W-1:0]  scale_ff;

   logic [lifs_pkg::PHASE_W-1:0]  cycle_len;
   logic [lifs_pkg::SUM_W-1:0]    sum;
   logic [lifs_pkg::ICON_W:0]     icon_sum;
   lifs_pkg::fade_kind_type       kind;
   logic [lifs_pkg::PHASE_W-1:0]  numer;
   logic [lifs_pkg::PHASE_W-1:0]  fade_dvs;

   logic                             div_start, div_busy;
   logic [lifs_pkg::PHASE_W-1:0]     div_rem_init, div_divisor, div_rem;
   logic [lifs_pkg::SUM_W-1:0]       div_bits;
   logic [lifs_pkg::DIV_STEP_W-1:0]  div_steps;
   logic [lifs_pkg::FADE_W-1:0]      div_quot;
   logic [lifs_pkg::ICON_W-1:0]      div_qmod;

   logic [lifs_pkg::COORD_W-1:0]     x_ff, y_ff;
   logic                             pix_last;
   logic                             advance;

   logic                             s1_valid_ff;
   logic [3*lifs_pkg::WEIGHT_W-1:0]  s1_weight_ff;
   logic [lifs_pkg::COORD_W-1:0]     s1_x_ff, s1_y_ff;
   logic                             s1_last_ff;

   logic                             out_valid_ff;
   logic [lifs_pkg::COORD_W-1:0]     out_x_ff, out_y_ff;
   logic [lifs_pkg::LEVEL_W-1:0]     out_r_ff, out_g_ff, out_b_ff;
   logic                             out_last_ff;
   logic [lifs_pkg::PROD_W-1:0]      prod_r, prod_g, prod_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff   <= lifs_pkg::BRIGHTNESS_RESET;
         damp_ff     <= lifs_pkg::DAMPING_RESET;
         fade_in_ff  <= lifs_pkg::FADE_IN_RESET;
         hold_ff     <= lifs_pkg::HOLD_RESET;
         fade_out_ff <= lifs_pkg::FADE_OUT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            lifs_pkg::REG_BRIGHTNESS_CAP: bright_ff   <= csr_data[lifs_pkg::GAIN_W-1:0];
            lifs_pkg::REG_DAMPING_GAIN:   damp_ff     <= csr_data[lifs_pkg::GAIN_W-1:0];
            lifs_pkg::REG_FADE_IN_TIME:   fade_in_ff  <= csr_data;
            lifs_pkg::REG_HOLD_TIME:      hold_ff     <= csr_data;
            lifs_pkg::REG_FADE_OUT_TIME:  fade_out_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cycle_len = lifs_pkg::PHASE_W'(hold_ff) + lifs_pkg::PHASE_W'(fade_out_ff);
      sum       = lifs_pkg::SUM_W'(phase_ff) + lifs_pkg::SUM_W'(delta_us);

      if (phase_ff < lifs_pkg::PHASE_W'(fade_in_ff)) begin
         kind = lifs_pkg::FADE_UP;
      end else if (phase_ff < lifs_pkg::PHASE_W'(hold_ff)) begin
         kind = lifs_pkg::FADE_HOLD;
      end else if (fade_out_ff == '0 || phase_ff >= cycle_len) begin
         kind = lifs_pkg::FADE_OFF;
      end else begin
         kind = lifs_pkg::FADE_DOWN;
      end

      if (kind == lifs_pkg::FADE_UP) begin
         numer    = phase_ff;
         fade_dvs = lifs_pkg::PHASE_W'(fade_in_ff);
      end else begin
         numer    = cycle_len - phase_ff;
         fade_dvs = lifs_pkg::PHASE_W'(fade_out_ff);
      end

      // The fade quotient is numer * 2^16 / divisor with numer not above the divisor,
      // so the top bits of the dividend are preloaded as the partial remainder.
      div_start = cmd.load_wrap | cmd.start_fade;
      if (cmd.load_wrap) begin
         div_rem_init = '0;
         div_bits     = sum;
         div_divisor  = cycle_len;
         div_steps    = lifs_pkg::DIV_STEP_W'(lifs_pkg::WRAP_STEPS);
      end else begin
         div_rem_init = numer >> 1;
         div_bits     = {numer[0], (lifs_pkg::SUM_W - 1)'(0)};
         div_divisor  = fade_dvs;
         div_steps    = lifs_pkg::DIV_STEP_W'(lifs_pkg::FADE_STEPS);
      end

      icon_sum = {1'b0, icon_ff} + {1'b0, div_qmod};
      if (32'(icon_sum) >= lifs_pkg::ICON_COUNT) begin
         icon_sum = icon_sum - (lifs_pkg::ICON_W + 1)'(lifs_pkg::ICON_COUNT);
      end

      phase_in = phase_ff;
      icon_in  = icon_ff;
      if (cmd.clear_phase) begin
         phase_in = '0;
      end else if (cmd.commit_wrap) begin
         phase_in = div_rem;
         icon_in  = lifs_pkg::ICON_W'(icon_sum);
      end
   end

   lifs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .rem_init  (div_rem_init),
      .bits_init (div_bits),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .rem       (div_rem),
      .quot      (div_quot),
      .qmod      (div_qmod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         icon_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         icon_ff  <= icon_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.const_fade) begin
         fade_ff <= (kind == lifs_pkg::FADE_HOLD) ? lifs_pkg::FADE_FULL : '0;
      end else if (cmd.commit_fade) begin
         fade_ff <= div_quot;
      end
      if (cmd.scale_a) begin
         bd_ff <= lifs_pkg::BD_W'(bright_ff) * lifs_pkg::BD_W'(damp_ff);
      end
      if (cmd.scale_b) begin
         scale_ff <= lifs_pkg::SCALE_W'(bd_ff) * lifs_pkg::SCALE_W'(fade_ff);
      end
   end

   assign advance  = !out_valid_ff || rsp_tready;
   assign pix_last = (x_ff == lifs_pkg::COORD_W'(lifs_pkg::GRID_WIDTH - 1)) &&
                     (y_ff == lifs_pkg::COORD_W'(lifs_pkg::GRID_HEIGHT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (cmd.pix_issue) begin
         if (x_ff == lifs_pkg::COORD_W'(lifs_pkg::GRID_WIDTH - 1)) begin
            x_ff <= '0;
            if (y_ff == lifs_pkg::COORD_W'(lifs_pkg::GRID_HEIGHT - 1)) begin
               y_ff <= '0;
            end else begin
               y_ff <= y_ff + lifs_pkg::COORD_W'(1);
            end
         end else begin
            x_ff <= x_ff + lifs_pkg::COORD_W'(1);
         end
      end
   end

   always_comb begin
      prod_r = lifs_pkg::PROD_W'(scale_ff) *
               lifs_pkg::PROD_W'(s1_weight_ff[3*lifs_pkg::WEIGHT_W-1:2*lifs_pkg::WEIGHT_W]);
      prod_g = lifs_pkg::PROD_W'(scale_ff) *
               lifs_pkg::PROD_W'(s1_weight_ff[2*lifs_pkg::WEIGHT_W-1:lifs_pkg::WEIGHT_W]);
      prod_b = lifs_pkg::PROD_W'(scale_ff) *
               lifs_pkg::PROD_W'(s1_weight_ff[lifs_pkg::WEIGHT_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.pix_issue;
         out_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s1_weight_ff <= lifs_pkg::pixel_weight(icon_ff,
            lifs_pkg::COORD_W'(lifs_pkg::GRID_HEIGHT - 1) - y_ff,
            lifs_pkg::COORD_W'(lifs_pkg::GRID_WIDTH - 1) - x_ff);
         s1_x_ff      <= x_ff;
         s1_y_ff      <= y_ff;
         s1_last_ff   <= pix_last;
         out_x_ff     <= s1_x_ff;
         out_y_ff     <= s1_y_ff;
         out_last_ff  <= s1_last_ff;
         out_r_ff     <= lifs_pkg::LEVEL_W'(prod_r >> lifs_pkg::LEVEL_SHIFT);
         out_g_ff     <= lifs_pkg::LEVEL_W'(prod_g >> lifs_pkg::LEVEL_SHIFT);
         out_b_ff     <= lifs_pkg::LEVEL_W'(prod_b >> lifs_pkg::LEVEL_SHIFT);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {lifs_pkg::RSP_PAD_W'(0), out_b_ff, out_g_ff, out_r_ff,
                        out_y_ff, out_x_ff};

   always_comb begin
      sts.cycle_zero   = cycle_len == '0;
      sts.div_busy     = div_busy;
      sts.fade_kind    = kind;
      sts.pipe_advance = advance;
      sts.pix_last     = pix_last;
      sts.s1_valid     = s1_valid_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/lifs_ctrl.sv =====
// Controller state machine that sequences timer update, fade division, scaling and pixel output.
`default_nettype none

module lifs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire lifs_pkg::sts_type  sts,
   output lifs_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRAP,
      S_FADE,
      S_FDIV,
      S_SCALE_A,
      S_SCALE_B,
      S_EMIT,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (sts.cycle_zero) begin
                  cmd.clear_phase = 1'b1;
                  state_in        = S_FADE;
               end else begin
                  cmd.load_wrap = 1'b1;
                  state_in      = S_WRAP;
               end
            end
         end
         S_WRAP: begin
            if (!sts.div_busy) begin
               cmd.commit_wrap = 1'b1;
               state_in        = S_FADE;
            end
         end
         S_FADE: begin
            if (sts.fade_kind == lifs_pkg::FADE_UP || sts.fade_kind == lifs_pkg::FADE_DOWN) begin
               cmd.start_fade = 1'b1;
               state_in       = S_FDIV;
            end else begin
               cmd.const_fade = 1'b1;
               state_in       = S_SCALE_A;
            end
         end
         S_FDIV: begin
            if (!sts.div_busy) begin
               cmd.commit_fade = 1'b1;
               state_in        = S_SCALE_A;
            end
         end
         S_SCALE_A: begin
            cmd.scale_a = 1'b1;
            state_in    = S_SCALE_B;
         end
         S_SCALE_B: begin
            cmd.scale_b = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (sts.pipe_advance) begin
               cmd.pix_issue = 1'b1;
               if (sts.pix_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!sts.s1_valid) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

`default_nettype wire

// ===== rtl/lifs_checker.sv =====
// Port-level checker for the icon fade sequencer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module lifs_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [lifs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast
);

   logic [lifs_pkg::RSP_DATA_W:0] rsp_word;
   logic                          rsp_corner;

   assign rsp_word   = {rsp_tlast, rsp_tdata};
   assign rsp_corner = (rsp_tdata[2:0] == lifs_pkg::COORD_W'(lifs_pkg::GRID_WIDTH - 1)) &&
                       (rsp_tdata[5:3] == lifs_pkg::COORD_W'(lifs_pkg::GRID_HEIGHT - 1));

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_word))

   `ASSERT_NEXT(a_req_one_frame, clock, reset, req_tvalid && req_tready, !req_tready)

   `ASSERT_SAME(a_last_corner, clock, reset, rsp_tvalid && rsp_tlast, rsp_corner)

   `ASSERT_SAME(a_no_req_mid_frame, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

endmodule

bind led_icon_fade_sequencer lifs_checker u_lifs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the LED icon fade sequencer: frame prediction and pixel checks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W         = lifs_pkg::COORD_W;
   localparam int LEVEL_W         = lifs_pkg::LEVEL_W;
   localparam int WEIGHT_W        = lifs_pkg::WEIGHT_W;
   localparam int ICON_COUNT      = lifs_pkg::ICON_COUNT;
   localparam int REQ_DATA_W      = lifs_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W      = lifs_pkg::RSP_DATA_W;
   localparam int CSR_IDX_W       = lifs_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W      = lifs_pkg::CSR_DATA_W;
   localparam int GAIN_W          = lifs_pkg::GAIN_W;
   localparam int TIME_W          = lifs_pkg::TIME_W;
   localparam int PHASE_W         = lifs_pkg::PHASE_W;
   localparam int ICON_W          = lifs_pkg::ICON_W;
   localparam int DELTA_W         = lifs_pkg::DELTA_W;
   localparam int FRAC_BITS       = lifs_pkg::FRAC_BITS;
   localparam int CELL_W          = lifs_pkg::CELL_W;
   localparam int PALETTE_ENTRIES = lifs_pkg::PALETTE_ENTRIES;
   localparam int GRID_WIDTH      = lifs_pkg::GRID_WIDTH;
   localparam int GRID_HEIGHT     = lifs_pkg::GRID_HEIGHT;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic               last;
   } pixel_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LATENCY_TAIL   = 150;
   localparam int REPORT_LINES   = 20;
   localparam int RANDOM_PHASES  = 5;
   localparam int FRAMES_PER_PHASE = 16;

   localparam logic [3*WEIGHT_W-1:0] palette_rgb [16] = '{
      24'h0DE60D, 24'h0DCD0D, 24'h402E0D, 24'h332608,
      24'h000000, 24'hFFA600, 24'hFF0000, 24'hFFFFF3,
      24'h000000, 24'h0DDA0D, 24'h8000CD, 24'h9A00FF,
      24'h00E6E6, 24'hE6DAB3, 24'h000000, 24'h000000
   };

   localparam logic [31:0] glyph_rows [ICON_COUNT][8] = '{
      '{32'h99999999, 32'h98899889, 32'h98899889, 32'h99988999,
        32'h99888899, 32'h99888899, 32'h99899899, 32'h99999999},
      '{32'h00000000, 32'h10110012, 32'h12212202, 32'h23223222,
        32'h22223222, 32'h23222232, 32'h22232222, 32'h22222222},
      '{32'h44444444, 32'h45544454, 32'h44544554, 32'h44444544,
        32'h44544444, 32'h44554444, 32'h44444544, 32'h45444444},
      '{32'h66666666, 32'h66666666, 32'h77777777, 32'h88888888,
        32'h78788787, 32'h77777777, 32'h66666666, 32'h66666666},
      '{32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888,
        32'hABA88ABA, 32'h88888888, 32'h88888888, 32'h88888888},
      '{32'h44444444, 32'h4CC444C4, 32'h44C44CC4, 32'h44444C44,
        32'h44C44444, 32'h44CC4444, 32'h44444C44, 32'h4C444444}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   logic [GAIN_W-1:0]  cap_level   = lifs_pkg::BRIGHTNESS_RESET;
   logic [GAIN_W-1:0]  damp_gain   = lifs_pkg::DAMPING_RESET;
   logic [TIME_W-1:0]  fade_in_us  = lifs_pkg::FADE_IN_RESET;
   logic [TIME_W-1:0]  hold_us     = lifs_pkg::HOLD_RESET;
   logic [TIME_W-1:0]  fade_out_us = lifs_pkg::FADE_OUT_RESET;
   logic [PHASE_W-1:0] phase_us    = '0;
   logic [ICON_W-1:0]  icon_sel    = '0;

   pixel_type pending_pixels [$];
   logic   quiet = 1'b0;
   int     rsp_stall_left = 0;
   int     idle_cycles = 0;
   int     mismatch_count = 0;
   int     frames_sent = 0;
   int     pixels_checked = 0;
   int     reg_writes = 0;

   led_icon_fade_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("frame %0d pixel %0d %s: got %0d, expected %0d",
                                   pixels_checked / 64, pixels_checked % 64, name, got, want));
      end
   endtask

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         lifs_pkg::REG_BRIGHTNESS_CAP: cap_level   = value[GAIN_W-1:0];
         lifs_pkg::REG_DAMPING_GAIN:   damp_gain   = value[GAIN_W-1:0];
         lifs_pkg::REG_FADE_IN_TIME:   fade_in_us  = value;
         lifs_pkg::REG_HOLD_TIME:      hold_us     = value;
         lifs_pkg::REG_FADE_OUT_TIME:  fade_out_us = value;
         default: ;
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] drive_level(input logic [WEIGHT_W-1:0] weight,
                                                      input u64_type fade);
      u64_type prod;
      prod = u64_type'(cap_level) * weight * fade * damp_gain;
      return prod[39:32];
   endfunction

   function automatic void predict_frame(input logic [DELTA_W-1:0] delta);
      u64_type cycle_len;
      u64_type total;
      u64_type t;
      u64_type fade;
      logic [31:0] row_word;
      logic [CELL_W-1:0] entry;
      logic [3*WEIGHT_W-1:0] rgb;
      pixel_type px;
      cycle_len = u64_type'(hold_us) + u64_type'(fade_out_us);
      total = u64_type'(phase_us) + u64_type'(delta);
      if (cycle_len == 0) begin
         phase_us = '0;
      end else begin
         phase_us = PHASE_W'(total % cycle_len);
         icon_sel = ICON_W'((u64_type'(icon_sel) + (total / cycle_len) % ICON_COUNT)
                            % ICON_COUNT);
      end
      t = u64_type'(phase_us);
      if (t < fade_in_us) begin
         fade = (t << FRAC_BITS) / fade_in_us;
      end else if (t < hold_us) begin
         fade = u64_type'(1) << FRAC_BITS;
      end else if (fade_out_us == 0 || t >= cycle_len) begin
         fade = 0;
      end else begin
         fade = ((cycle_len - t) << FRAC_BITS) / fade_out_us;
      end
      for (int y = 0; y < GRID_HEIGHT; y++) begin
         for (int x = 0; x < GRID_WIDTH; x++) begin
            row_word = (icon_sel < ICON_COUNT) ? glyph_rows[icon_sel][GRID_HEIGHT-1-y] : '0;
            entry = row_word[CELL_W*x +: CELL_W];
            rgb = (entry < PALETTE_ENTRIES) ? palette_rgb[entry] : '0;
            px.x = COORD_W'(x);
            px.y = COORD_W'(y);
            px.red = drive_level(rgb[23:16], fade);
            px.green = drive_level(rgb[15:8], fade);
            px.blue = drive_level(rgb[7:0], fade);
            px.last = (x == GRID_WIDTH - 1) && (y == GRID_HEIGHT - 1);
            pending_pixels.push_back(px);
         end
      end
   endfunction

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("rsp transaction with no pixel expected");
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", 32'(rsp_tdata[2:0]), 32'(want.x));
            check_field("pixel_y", 32'(rsp_tdata[5:3]), 32'(want.y));
            check_field("red_level", 32'(rsp_tdata[13:6]), 32'(want.red));
            check_field("green_level", 32'(rsp_tdata[21:14]), 32'(want.green));
            check_field("blue_level", 32'(rsp_tdata[29:22]), 32'(want.blue));
            check_field("frame_last", 32'(rsp_tlast), 32'(want.last));
            pixels_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall_left <= $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: no transaction for %0d cycles, %0d pixels still expected",
                  idle_cycles, pending_pixels.size());
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_frame(input logic [DELTA_W-1:0] delta);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - DELTA_W){1'b0}}, delta};
      do @(posedge clock); while (!req_tready);
      predict_frame(delta);
      frames_sent++;
   endtask

   task automatic drain_frames();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, value);
      reg_writes++;
   endtask

   task automatic write_all(input logic [CSR_DATA_W-1:0] cap, input logic [CSR_DATA_W-1:0] damp,
                            input logic [TIME_W-1:0] fade_in, input logic [TIME_W-1:0] hold,
                            input logic [TIME_W-1:0] fade_out);
      write_reg(lifs_pkg::REG_BRIGHTNESS_CAP, cap);
      write_reg(lifs_pkg::REG_DAMPING_GAIN, damp);
      write_reg(lifs_pkg::REG_FADE_IN_TIME, fade_in);
      write_reg(lifs_pkg::REG_HOLD_TIME, hold);
      write_reg(lifs_pkg::REG_FADE_OUT_TIME, fade_out);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] cap,
                                input logic [CSR_DATA_W-1:0] damp,
                                input logic [TIME_W-1:0] fade_in, input logic [TIME_W-1:0] hold,
                                input logic [TIME_W-1:0] fade_out);
      drain_frames();
      write_all(cap, damp, fade_in, hold, fade_out);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 7))
         0: return TIME_W'(1);
         1: return {TIME_W{1'b1}};
         2: return TIME_W'($urandom_range(1, 64));
         3, 4: return TIME_W'($urandom_range(1000, 300000));
         5: return TIME_W'($urandom);
         6: return TIME_W'($urandom_range(0, 3));
         default: return TIME_W'($urandom_range(100000, 2000000));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      logic [GAIN_W-1:0] gain;
      case ($urandom_range(0, 3))
         0: gain = '0;
         1: gain = '1;
         default: gain = GAIN_W'($urandom);
      endcase
      return {(CSR_DATA_W - GAIN_W)'($urandom), gain};
   endfunction

   function automatic logic [DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return DELTA_W'($urandom_range(0, 5000));
         default: return DELTA_W'($urandom);
      endcase
   endfunction

   task automatic test_default_timing();
      send_frame(DELTA_W'(0));
      send_frame(DELTA_W'(250000));
      repeat (4) send_frame({DELTA_W{1'b1}});
   endtask

   task automatic test_gain_extremes();
      load_settings(24'd255, 24'd255, 24'd1, {TIME_W{1'b1}}, 24'd1);
      send_frame(DELTA_W'(3));
      load_settings(24'd0, 24'd255, 24'd1, {TIME_W{1'b1}}, 24'd1);
      send_frame(DELTA_W'(7));
      load_settings(24'hFFFF80, 24'h000100, 24'd1, {TIME_W{1'b1}}, 24'd1);
      send_frame(DELTA_W'(11));
   endtask

   task automatic test_cycle_wrap_burst();
      load_settings(24'd255, 24'd200, 24'd1, 24'd1, 24'd1);
      send_frame({DELTA_W{1'b1}});
      send_frame(DELTA_W'(20'hFFFFE));
      send_frame(DELTA_W'(20'h55555));
   endtask

   task automatic test_fade_in_past_hold();
      load_settings(24'd255, 24'd255, 24'd1500, 24'd1000, 24'd1000);
      send_frame(DELTA_W'(1200));
      send_frame(DELTA_W'(400));
      send_frame(DELTA_W'(500));
   endtask

   task automatic test_no_fade_in();
      load_settings(24'd255, 24'd255, 24'd0, 24'd1000, 24'd3000);
      send_frame(DELTA_W'(0));
      send_frame(DELTA_W'(2000));
      send_frame(DELTA_W'(2000));
   endtask

   task automatic test_zero_cycle();
      load_settings(24'd255, 24'd255, 24'd0, 24'd0, 24'd0);
      send_frame({DELTA_W{1'b1}});
      send_frame(DELTA_W'(5));
   endtask

   task automatic test_unused_index();
      drain_frames();
      write_all(24'd200, 24'd128, 24'd300, 24'd2000, 24'd1500);
      for (int i = int'(lifs_pkg::REG_FADE_OUT_TIME) + 1; i < (1 << CSR_IDX_W); i++) begin
         write_reg(CSR_IDX_W'(i), '0);
      end
      csr_valid <= 1'b0;
      send_frame(DELTA_W'(700));
   endtask

   task automatic test_random_frames();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_settings(pick_gain(), pick_gain(), pick_time(), pick_time(), pick_time());
         if (p == RANDOM_PHASES - 1) begin
            quiet <= 1'b1;
         end
         repeat (FRAMES_PER_PHASE) send_frame(pick_delta());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_gain_extremes();
      test_cycle_wrap_burst();
      test_fade_in_past_hold();
      test_no_fade_in();
      test_zero_cycle();
      test_unused_index();
      test_random_frames();
      drain_frames();
      repeat (LATENCY_TAIL) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
      end
      $display("tb_top: %0d frames, %0d pixels checked, %0d register writes", frames_sent,
               pixels_checked, reg_writes);
      $display("tb_top: covered fade ramps, multi-cycle wraps, zero-length cycle, %s",
               "no fade-in and unused register indexes");
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== led_icon_fade_sequencer.f =====
+incdir+rtl
rtl/lifs_pkg.sv
rtl/lifs_div.sv
rtl/lifs_datapath.sv
rtl/lifs_ctrl.sv
rtl/led_icon_fade_sequencer.sv
rtl/lifs_checker.sv
tb/sv/tb_top.sv
